// ----- design/itoa_pkg.sv -----
// Shared types, constants and helper functions for the integer-to-ASCII converter.
// No dependencies; imported by the top level and itoa_divstep.
package itoa_pkg;

	localparam int VALUE_W        = 64;
	localparam int RADIX_W        = 6;
	localparam int ROOM_W         = 7;
	localparam int CHAR_W         = 8;
	localparam int CNT_W          = 7;
	localparam int SHIFT_W        = 3;
	localparam int DIV_BITS       = 8;
	localparam int MAX_DIGITS_DEF = 64;
	localparam int VALUE_BITS_DEF = 64;

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [CHAR_W-1:0]  CH_ZERO       = 8'h30;
	localparam logic [CHAR_W-1:0]  CH_ALPHA_BASE = 8'h57;
	localparam logic [RADIX_W-1:0] DEC_DIGITS    = 6'd10;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
		logic [ROOM_W-1:0]  room;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last_char;
		logic              status;
	} rsp_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
		if (d < DEC_DIGITS) begin
			return CH_ZERO + dx;
		end
		return CH_ALPHA_BASE + dx;
	endfunction

	// Shift amount for power-of-two bases, zero for all others
	function automatic logic [SHIFT_W-1:0] pow2_shift(input logic [RADIX_W-1:0] r);
		logic [SHIFT_W-1:0] s;
		unique case (r)
			6'd2:    s = 3'd1;
			6'd4:    s = 3'd2;
			6'd8:    s = 3'd3;
			6'd16:   s = 3'd4;
			6'd32:   s = 3'd5;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

// ----- design/integer_to_ascii_radix_top.sv -----
// Top level of the unsigned integer to ASCII converter, bases 2 to 36.
// Depends on itoa_pkg, itoa_ram and itoa_divstep.
//
// Usage: present value, radix and room on req_data with req_valid; the
// transfer happens when req_ready is also high. req_ready is high only while
// the converter is idle. Characters come out on rsp_data, most significant
// digit first, one per rsp transfer; last_char marks the final one. When the
// digits do not fit in room, a single response with status set, out_char 0
// and last_char set is the whole answer. Radix saturates to 2..36, room
// saturates to MAX_DIGITS, value bits above VALUE_BITS are ignored.
// Conversion: power-of-two bases take each digit by mask and shift;
// other bases run each digit through the shared 8-bit divider step,
// 8 bits of the value at a time. Emission then reads the digit RAM at one
// character per cycle while the receiver keeps up; the RAM read data is
// registered before it reaches the output register.
// A stalled receiver holds the output register and pauses RAM reads; no
// character is lost. The next item may be accepted while the final
// character still waits in the output register. Reset returns to idle
// with no response pending; the digit RAM needs no clearing.
module integer_to_ascii_radix_top import itoa_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	localparam int STEPS  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
	localparam int WORK_W = STEPS * DIV_BITS;
	localparam int AW     = $clog2(MAX_DIGITS);
	localparam int SW     = $clog2(STEPS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CONV   = 4'b0010,
		ST_EMIT   = 4'b0100,
		ST_NOROOM = 4'b1000
	} state_t;

	state_t             state_q;
	logic [WORK_W-1:0]  val_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [ROOM_W-1:0]  room_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SW-1:0]      step_q;
	logic               ovf_q;
	logic               rd_pend_q;
	logic               rd_last_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic [RADIX_W-1:0] radix_sat;
	logic [ROOM_W-1:0]  room_sat;
	logic [WORK_W-1:0]  div_q;
	logic [RADIX_W-1:0] div_r;
	logic               pow2;
	logic [RADIX_W-1:0] p2_digit;
	logic [WORK_W-1:0]  p2_next;
	logic               digit_done;
	logic [RADIX_W-1:0] digit_val;
	logic [WORK_W-1:0]  next_val;
	logic               store_ok;
	logic               conv_end;
	logic [CNT_W-1:0]   n_next;
	logic               no_room;
	logic               can_load;
	logic               rd_issue;
	logic               rd_load;
	logic               nr_load;
	logic [CNT_W-1:0]   cnt_dec;
	logic [CHAR_W-1:0]  ram_rdata;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		radix_sat = req_data.radix;
		if (req_data.radix < RADIX_MIN) begin
			radix_sat = RADIX_MIN;
		end else if (req_data.radix > RADIX_MAX) begin
			radix_sat = RADIX_MAX;
		end
		room_sat = req_data.room;
		if (req_data.room > ROOM_W'(MAX_DIGITS)) begin
			room_sat = ROOM_W'(MAX_DIGITS);
		end
	end

	itoa_divstep #(
		.WORK_W(WORK_W)
	) u_divstep (
		.q_i  (val_q),
		.r_i  (rem_q),
		.radix(radix_q),
		.q_o  (div_q),
		.r_o  (div_r)
	);

	assign pow2     = (shift_q != '0);
	assign p2_digit = {1'b0, val_q[4:0] & (radix_q[4:0] - 5'd1)};
	assign p2_next  = val_q >> shift_q;

	assign digit_done = (state_q == ST_CONV) && (pow2 || (step_q == SW'(STEPS - 1)));
	assign digit_val  = pow2 ? p2_digit : div_r;
	assign next_val   = pow2 ? p2_next : div_q;
	assign store_ok   = (cnt_q < CNT_W'(MAX_DIGITS));
	assign conv_end   = digit_done && (next_val == '0);
	assign n_next     = cnt_q + CNT_W'(1);
	assign no_room    = ovf_q || !store_ok || (n_next > room_q);

	assign can_load = !rsp_valid_q || rsp_ready;
	assign rd_issue = (state_q == ST_EMIT) && (cnt_q != '0) && (!rd_pend_q || can_load);
	assign rd_load  = (state_q == ST_EMIT) && rd_pend_q && can_load;
	assign nr_load  = (state_q == ST_NOROOM) && can_load;
	assign cnt_dec  = cnt_q - CNT_W'(1);

	itoa_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_DIGITS)
	) u_store (
		.clk  (clk),
		.we   (digit_done && store_ok),
		.waddr(cnt_q[AW-1:0]),
		.wdata(digit_char(digit_val)),
		.re   (rd_issue),
		.raddr(cnt_dec[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			step_q    <= '0;
			ovf_q     <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						step_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (digit_done) begin
						step_q <= '0;
						cnt_q  <= n_next;
						if (!store_ok) begin
							ovf_q <= 1'b1;
						end
						if (conv_end) begin
							rd_pend_q <= 1'b0;
							rd_last_q <= 1'b0;
							state_q   <= no_room ? ST_NOROOM : ST_EMIT;
						end
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				ST_EMIT: begin
					if (rd_issue) begin
						cnt_q     <= cnt_dec;
						rd_pend_q <= 1'b1;
						rd_last_q <= (cnt_q == CNT_W'(1));
					end else if (rd_load) begin
						rd_pend_q <= 1'b0;
					end
					if (rd_load && rd_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_NOROOM: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working value and remainder, plus the radix, shift and room latched on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q   <= WORK_W'(req_data.value[VALUE_BITS-1:0]);
			rem_q   <= '0;
			radix_q <= radix_sat;
			shift_q <= pow2_shift(radix_sat);
			room_q  <= room_sat;
		end else if (state_q == ST_CONV) begin
			val_q <= next_val;
			// drop the remainder once a digit is taken
			rem_q <= digit_done ? '0 : div_r;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rd_load || nr_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_load) begin
			rsp_q <= '{out_char: ram_rdata, last_char: rd_last_q, status: 1'b0};
		end else if (nr_load) begin
			rsp_q <= '{out_char: '0, last_char: 1'b1, status: 1'b1};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- design/itoa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the converted digits.
module itoa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/itoa_divstep.sv -----
// Shared divider step: DIV_BITS bits of restoring long division by the radix.
// Depends on itoa_pkg.
module itoa_divstep import itoa_pkg::*; #(
	parameter int WORK_W = 64
) (
	input  logic [WORK_W-1:0]  q_i,
	input  logic [RADIX_W-1:0] r_i,
	input  logic [RADIX_W-1:0] radix,
	output logic [WORK_W-1:0]  q_o,
	output logic [RADIX_W-1:0] r_o
);

	always_comb begin
		logic [WORK_W-1:0]  q;
		logic [RADIX_W:0]   r7;
		logic [RADIX_W-1:0] r;
		q = q_i;
		r = r_i;
		for (int i = 0; i < DIV_BITS; i++) begin
			// remainder stays below the radix, so one more bit fits in RADIX_W+1
			r7 = {r, q[WORK_W-1]};
			q  = {q[WORK_W-2:0], 1'b0};
			if (r7 >= {1'b0, radix}) begin
				r7   = r7 - {1'b0, radix};
				q[0] = 1'b1;
			end
			r = r7[RADIX_W-1:0];
		end
		q_o = q;
		r_o = r;
	end

endmodule

// ----- tb/sv/integer_to_ascii_radix_top_test.sv -----
// Self-checking bench for integer_to_ascii_radix_top: directed probes, then random values and bases.
// Depends on itoa_pkg and the converter RTL; each character is checked against literal text or a local digit speller.
module integer_to_ascii_radix_top_test;
	import itoa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PROBE_COUNT  = 25;
	localparam int RANDOM_ITEMS = 125;
	localparam int STORE_DEPTH  = 64;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;

	localparam logic       STATUS_OK      = 1'b0;
	localparam logic       STATUS_NO_ROOM = 1'b1;
	localparam logic [7:0] ASCII_ZERO     = "0";
	localparam logic [7:0] ASCII_ALPHA    = "a";
	localparam logic [63:0] ALL_ONES      = 64'hffff_ffff_ffff_ffff;

	typedef enum {ANS_COMPUTED, ANS_TEXT, ANS_NO_ROOM} answer_e;

	typedef struct {
		logic [63:0] value;
		logic [5:0]  radix;
		logic [6:0]  room;
		answer_e     how;
		string       text;
	} probe_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	rsp_t   expected_chars[$];
	int     mismatches;
	int     delivered;
	bit     no_idle;
	probe_t probes [PROBE_COUNT];

	integer_to_ascii_radix_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#100_000_000;
		$display("integer_to_ascii_radix_top_test: FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Spell v in the given base, most significant digit first; returns the digit count.
	function automatic int spell_digits(input logic [63:0] v, input logic [5:0] radix,
			output logic [7:0] text [STORE_DEPTH]);
		logic [63:0] rest;
		logic [63:0] base;
		logic [63:0] d;
		logic [7:0]  lsd_first [STORE_DEPTH];
		int          n;
		base = (radix < 6'd2) ? 64'd2 : (radix > 6'd36) ? 64'd36 : 64'(radix);
		rest = v;
		n = 0;
		do begin
			d = rest % base;
			rest = rest / base;
			lsd_first[n] = (d < 64'd10) ? ASCII_ZERO + d[7:0] : ASCII_ALPHA - 8'd10 + d[7:0];
			n++;
		end while (rest != 64'd0);
		for (int k = 0; k < STORE_DEPTH; k++) begin
			text[k] = (k < n) ? lsd_first[n - 1 - k] : 8'h00;
		end
		return n;
	endfunction

	function automatic void expect_no_room();
		rsp_t r;
		r.out_char  = 8'h00;
		r.last_char = 1'b1;
		r.status    = STATUS_NO_ROOM;
		expected_chars.push_back(r);
	endfunction

	function automatic void expect_text(input string s);
		rsp_t r;
		for (int k = 0; k < s.len(); k++) begin
			r.out_char  = s[k];
			r.last_char = (k == s.len() - 1);
			r.status    = STATUS_OK;
			expected_chars.push_back(r);
		end
	endfunction

	function automatic void predict_rendering(input req_t item);
		logic [7:0] text [STORE_DEPTH];
		rsp_t       r;
		int         n;
		int         space;
		n = spell_digits(item.value, item.radix, text);
		space = (item.room > 7'(STORE_DEPTH)) ? STORE_DEPTH : int'(item.room);
		if (n > space) begin
			expect_no_room();
		end else begin
			for (int k = 0; k < n; k++) begin
				r.out_char  = text[k];
				r.last_char = (k == n - 1);
				r.status    = STATUS_OK;
				expected_chars.push_back(r);
			end
		end
	endfunction

	// Mostly short idle stretches, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(9, 0) == 0) begin
			return $urandom_range(50, 15);
		end
		return $urandom_range(3, 1);
	endfunction

	// Enter and leave at a falling edge; valid stays high across back-to-back items.
	task automatic offer(input req_t item, input answer_e how, input string text);
		int gap;
		gap = (!no_idle && $urandom_range(2, 0) == 0) ? gap_length() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_data  <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		case (how)
			ANS_TEXT:    expect_text(text);
			ANS_NO_ROOM: expect_no_room();
			default:     predict_rendering(item);
		endcase
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			delivered++;
			if (expected_chars.size() == 0) begin
				flag_mismatch($sformatf("unexpected transfer char=%h last=%b status=%b",
					rsp_data.out_char, rsp_data.last_char, rsp_data.status));
			end else begin
				want = expected_chars.pop_front();
				if (rsp_data.out_char !== want.out_char) begin
					flag_mismatch($sformatf("out_char %h, want %h", rsp_data.out_char,
						want.out_char));
				end
				if (rsp_data.last_char !== want.last_char) begin
					flag_mismatch($sformatf("last_char %b, want %b", rsp_data.last_char,
						want.last_char));
				end
				if (rsp_data.status !== want.status) begin
					flag_mismatch($sformatf("status %b, want %b", rsp_data.status,
						want.status));
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off so the converter backs up.
	initial begin
		int stall;
		bit held;
		stall = 0;
		held = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && delivered >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (stall > 0) begin
				stall--;
			end else if (!no_idle && $urandom_range(4, 0) == 0) begin
				stall = gap_length();
			end
			rsp_ready <= (stall == 0);
		end
	end

	initial begin
		req_t       item;
		logic [7:0] scratch [STORE_DEPTH];
		logic [63:0] v;
		int         n;
		int         width;
		int         pick;
		req_valid = 1'b0;
		req_data  = '0;
		mismatches = 0;
		delivered = 0;
		no_idle = 1'b0;
		probes = '{
			'{64'd0, 6'd10, 7'd1, ANS_TEXT, "0"},
			'{64'd0, 6'd10, 7'd0, ANS_NO_ROOM, ""},
			'{64'd0, 6'd1, 7'd1, ANS_TEXT, "0"},
			'{64'd0, 6'd63, 7'd127, ANS_TEXT, "0"},
			'{ALL_ONES, 6'd16, 7'd64, ANS_TEXT, "ffffffffffffffff"},
			'{ALL_ONES, 6'd16, 7'd15, ANS_NO_ROOM, ""},
			'{ALL_ONES, 6'd2, 7'd64, ANS_COMPUTED, ""},
			'{ALL_ONES, 6'd2, 7'd63, ANS_NO_ROOM, ""},
			'{ALL_ONES, 6'd1, 7'd127, ANS_COMPUTED, ""},
			'{ALL_ONES, 6'd36, 7'd13, ANS_COMPUTED, ""},
			'{ALL_ONES, 6'd36, 7'd12, ANS_COMPUTED, ""},
			'{ALL_ONES, 6'd10, 7'd20, ANS_TEXT, "18446744073709551615"},
			'{ALL_ONES, 6'd10, 7'd19, ANS_NO_ROOM, ""},
			'{64'd35, 6'd36, 7'd1, ANS_TEXT, "z"},
			'{64'd35, 6'd63, 7'd1, ANS_TEXT, "z"},
			'{64'd9, 6'd10, 7'd1, ANS_TEXT, "9"},
			'{64'd10, 6'd10, 7'd1, ANS_NO_ROOM, ""},
			'{64'd10, 6'd10, 7'd2, ANS_TEXT, "10"},
			'{64'd255, 6'd8, 7'd3, ANS_TEXT, "377"},
			'{64'd1000, 6'd10, 7'd4, ANS_TEXT, "1000"},
			'{64'd31, 6'd32, 7'd1, ANS_TEXT, "v"},
			'{64'h8000_0000_0000_0000, 6'd4, 7'd127, ANS_COMPUTED, ""},
			'{64'h0123_4567_89ab_cdef, 6'd16, 7'd15, ANS_TEXT, "123456789abcdef"},
			'{64'h5555_5555_5555_5555, 6'd3, 7'd64, ANS_COMPUTED, ""},
			'{64'haaaa_aaaa_aaaa_aaaa, 6'd37, 7'd65, ANS_COMPUTED, ""}
		};
		@(posedge arst_n);
		@(negedge clk);

		foreach (probes[i]) begin
			item.value = probes[i].value;
			item.radix = probes[i].radix;
			item.room  = probes[i].room;
			offer(item, probes[i].how, probes[i].text);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = (i >= 50 && i < 80);
			// Pick a bit length first so short values show up as often as long ones.
			width = $urandom_range(64, 0);
			v = {$urandom(), $urandom()};
			if (width < 64) begin
				v &= (64'd1 << width) - 64'd1;
			end
			item.value = v;
			item.radix = ($urandom_range(12, 0) != 0) ? 6'($urandom_range(36, 2))
				: 6'($urandom_range(63, 0));
			n = spell_digits(item.value, item.radix, scratch);
			pick = $urandom_range(9, 0);
			case (pick)
				0, 1, 2, 3, 4, 5: item.room = 7'(n + $urandom_range(3, 0));
				6:                item.room = 7'(n - 1);
				7:                item.room = 7'($urandom_range(127, 64));
				8:                item.room = 7'($urandom_range(127, 0));
				default:          item.room = 7'(n);
			endcase
			offer(item, ANS_COMPUTED, "");
		end
		req_valid <= 1'b0;
		no_idle = 1'b0;

		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("integer_to_ascii_radix_top_test: PASS");
		end else begin
			$display("integer_to_ascii_radix_top_test: FAIL");
		end
		$finish;
	end

endmodule
